[hw/rtl/plpd_pkg.sv]
// ----------------------------------------------------------------------------
// plpd_pkg
// Shared types, constants and helpers of the polyline placement block.
// ----------------------------------------------------------------------------
`default_nettype none

package plpd_pkg;

  localparam int unsigned PLPD_QDEPTH = 2;
  localparam logic [31:0] PLPD_ONE_Q30 = 32'h4000_0000;

  // one vertex as handed from the front to the back
  typedef struct packed {
    logic [2:0][31:0] cur;
    logic [2:0][32:0] seg;
    logic             last;
    logic             has_seg;
  } plpd_entry_t;

  typedef struct packed {
    logic        valid;
    plpd_entry_t entry;
  } plpd_q_t;

  typedef struct packed {
    logic [2:0][31:0] side;
    logic [2:0][31:0] nrm;
    logic [2:0][31:0] fwd;
    logic [2:0][31:0] pos;
  } plpd_result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEG_SQ, ST_SEG_RT_GO, ST_SEG_RT_W, ST_HIT, ST_F_GO, ST_F_W,
    ST_POS, ST_N_LOAD, ST_N_SHIFT, ST_N_SQ, ST_N_RT_GO, ST_N_RT_W,
    ST_N_DIV_GO, ST_N_DIV_W, ST_N_RET, ST_X_MUL, ST_FIN, ST_EMIT
  } plpd_state_t;

  typedef enum logic [1:0] {
    PH_SIDE, PH_FWD, PH_NRM
  } plpd_phase_t;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = v[32] ? (33'd0 - v) : v;
    return n[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/plpd_front.sv]
// ----------------------------------------------------------------------------
// plpd_front
// Accepts vertices, forms the segment vector and tracks the previous vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module plpd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic               in_last_point,
  input  wire logic               q_full,
  output logic                    push,
  output plpd_pkg::plpd_entry_t   entry
);
  import plpd_pkg::*;

  logic [2:0][31:0] prev_r;
  logic             have_prev_r;
  logic [2:0][31:0] cur;

  assign cur      = {in_point_z, in_point_y, in_point_x};
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    entry.cur     = cur;
    entry.last    = in_last_point;
    entry.has_seg = have_prev_r;
    for (int i = 0; i < 3; i++) begin
      entry.seg[i] = {cur[i][31], cur[i]} - {prev_r[i][31], prev_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else if (push) begin
      have_prev_r <= !in_last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      prev_r <= cur;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/plpd_queue.sv]
// ----------------------------------------------------------------------------
// plpd_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module plpd_queue #(
  parameter int unsigned DEPTH = plpd_pkg::PLPD_QDEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire plpd_pkg::plpd_entry_t push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output plpd_pkg::plpd_q_t          head
);
  import plpd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  plpd_entry_t     ent_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = ent_r[rd_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/plpd_sqrt.sv]
// ----------------------------------------------------------------------------
// plpd_sqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plpd_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [65:0] rad,
  output logic             done,
  output logic [32:0]      root
);
  logic [65:0] rad_r;
  logic [36:0] rem_r;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [36:0] rem_sh;
  logic [36:0] trial;

  assign rem_sh = {rem_r[34:0], rad_r[65:64]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[31:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[31:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/plpd_div.sv]
// ----------------------------------------------------------------------------
// plpd_div
// Restoring divider for quotients below 2^32, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plpd_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [31:0]      quo
);
  logic [33:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] q_r;
  logic [32:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] rem_sh;

  // caller keeps num[63:32] below den
  assign rem_sh = {rem_r[32:0], lo_r[31]};
  assign done   = done_r;
  assign quo    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num[63:32]};
      lo_r  <= num[31:0];
      q_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      lo_r <= {lo_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/plpd_back.sv]
// ----------------------------------------------------------------------------
// plpd_back
// Sequencer for arc length, hit test, interpolation and frame normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module plpd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [31:0]            cfg_wr_data,
  input  wire plpd_pkg::plpd_q_t      head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output plpd_pkg::plpd_result_t      result
);
  import plpd_pkg::*;

  plpd_state_t      state_r, state_nxt;
  plpd_phase_t      phase_r;
  logic [2:0]       cnt_r;
  logic [31:0]      target_r;
  logic [39:0]      run_r;
  logic             emitted_r;
  logic             out_valid_r;
  plpd_result_t     out_r;

  logic [2:0][31:0] cur_r;
  logic [2:0][32:0] seg_r;
  logic             last_r;
  logic [65:0]      sq_r;
  logic [32:0]      d_r;
  logic [32:0]      ex_r;
  logic [30:0]      f_r;
  logic signed [65:0] prod_r;
  logic [2:0][31:0] pos_r, side_r, fwd_r, nrm_r, nq_r;
  logic [2:0][63:0] nv_r, na_r;
  logic [63:0]      nm_r;
  logic [63:0]      ns_r;
  logic [32:0]      nn_r;

  logic signed [32:0] mul_a, mul_b;
  logic             sqrt_start, div_start, sqrt_done, div_done;
  logic [65:0]      sqrt_rad;
  logic [32:0]      sqrt_root;
  logic [63:0]      div_num;
  logic [32:0]      div_den;
  logic [31:0]      div_quo;
  logic             slot_free;
  logic [40:0]      run_sum;
  logic [39:0]      run_sat;
  logic [39:0]      ex_full;
  logic             hit;
  logic [1:0]       pidx;
  logic [33:0]      dm;
  logic [63:0]      nmax;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign result    = out_r;

  assign run_sum = {1'b0, run_r} + {8'd0, d_r};
  assign run_sat = run_sum[40] ? '1 : run_sum[39:0];
  assign hit     = run_sat >= {8'd0, target_r};
  assign ex_full = run_sat - {8'd0, target_r};
  assign pidx    = cnt_r[1:0] - 2'd1;
  assign dm      = 34'((prod_r[63:0] + 64'h2000_0000) >> 30);

  // largest component magnitude of the vector to normalize
  always_comb begin
    nmax = '0;
    for (int i = 0; i < 3; i++) begin
      if (mag64(nv_r[i]) > nmax) nmax = mag64(nv_r[i]);
    end
  end

  plpd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  plpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt = (head.entry.has_seg && !emitted_r) ? ST_SEG_SQ : ST_FIN;
        end
      end
      ST_SEG_SQ:    if (cnt_r == 3'd3) state_nxt = ST_SEG_RT_GO;
      ST_SEG_RT_GO: state_nxt = ST_SEG_RT_W;
      ST_SEG_RT_W:  if (sqrt_done) state_nxt = ST_HIT;
      ST_HIT: begin
        if (!hit) begin
          state_nxt = ST_FIN;
        end else if (d_r == '0 || ex_full > {7'd0, d_r}) begin
          state_nxt = ST_POS;
        end else begin
          state_nxt = ST_F_GO;
        end
      end
      ST_F_GO:      state_nxt = ST_F_W;
      ST_F_W:       if (div_done) state_nxt = ST_POS;
      ST_POS:       if (cnt_r == 3'd3) state_nxt = ST_N_LOAD;
      ST_N_LOAD:    state_nxt = ST_N_SHIFT;
      ST_N_SHIFT: begin
        if (nm_r == '0) begin
          state_nxt = ST_N_RET;
        end else if (nm_r >= 64'h8000_0000 || nm_r < 64'h4000_0000) begin
          state_nxt = ST_N_SHIFT;
        end else begin
          state_nxt = ST_N_SQ;
        end
      end
      ST_N_SQ:      if (cnt_r == 3'd3) state_nxt = ST_N_RT_GO;
      ST_N_RT_GO:   state_nxt = ST_N_RT_W;
      ST_N_RT_W:    if (sqrt_done) state_nxt = ST_N_DIV_GO;
      ST_N_DIV_GO:  state_nxt = ST_N_DIV_W;
      ST_N_DIV_W: begin
        if (div_done) state_nxt = (cnt_r == 3'd2) ? ST_N_RET : ST_N_DIV_GO;
      end
      ST_N_RET: begin
        unique case (phase_r)
          PH_SIDE: state_nxt = ST_N_LOAD;
          PH_FWD:  state_nxt = ST_X_MUL;
          PH_NRM:  state_nxt = ST_EMIT;
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_X_MUL:     if (cnt_r == 3'd4) state_nxt = ST_N_LOAD;
      ST_FIN:       state_nxt = (last_r && !emitted_r) ? ST_EMIT : ST_IDLE;
      ST_EMIT:      if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    sqrt_rad   = sq_r;
    div_num    = {1'b0, ex_r, 30'd0};
    div_den    = d_r;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      ST_IDLE:      pop = head.valid;
      ST_SEG_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = {1'b0, mag33(seg_r[cnt_r[1:0]])};
          mul_b = {1'b0, mag33(seg_r[cnt_r[1:0]])};
        end
      end
      ST_SEG_RT_GO: sqrt_start = 1'b1;
      ST_F_GO:      div_start = 1'b1;
      ST_POS: begin
        if (cnt_r < 3'd3) begin
          mul_a = {1'b0, mag33(seg_r[cnt_r[1:0]])};
          mul_b = {2'b00, f_r};
        end
      end
      ST_N_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = {2'b00, na_r[cnt_r[1:0]][30:0]};
          mul_b = {2'b00, na_r[cnt_r[1:0]][30:0]};
        end
      end
      ST_N_RT_GO: begin
        sqrt_start = 1'b1;
        sqrt_rad   = {2'b00, ns_r};
      end
      ST_N_DIV_GO: begin
        div_start = 1'b1;
        div_num   = {na_r[cnt_r[1:0]][33:0], 30'd0} + {31'd0, nn_r[32:1]};
        div_den   = nn_r;
      end
      ST_X_MUL: begin
        unique case (cnt_r)
          3'd0: begin
            mul_a = {side_r[1][31], side_r[1]};
            mul_b = {fwd_r[2][31], fwd_r[2]};
          end
          3'd1: begin
            mul_a = {side_r[0][31], side_r[0]};
            mul_b = {fwd_r[2][31], fwd_r[2]};
          end
          3'd2: begin
            mul_a = {side_r[0][31], side_r[0]};
            mul_b = {fwd_r[1][31], fwd_r[1]};
          end
          3'd3: begin
            mul_a = {side_r[1][31], side_r[1]};
            mul_b = {fwd_r[0][31], fwd_r[0]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      run_r       <= '0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_HIT) begin
        run_r <= run_sat;
      end
      if (state_r == ST_FIN && last_r && emitted_r) begin
        run_r     <= '0;
        emitted_r <= 1'b0;
      end
      if (state_r == ST_EMIT && slot_free) begin
        emitted_r   <= !last_r;
        if (last_r) run_r <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        cur_r  <= head.entry.cur;
        seg_r  <= head.entry.seg;
        last_r <= head.entry.last;
        cnt_r  <= '0;
        sq_r   <= '0;
      end
      ST_SEG_SQ: begin
        if (cnt_r != 3'd0) sq_r <= sq_r + {2'b00, prod_r[63:0]};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_SEG_RT_W: begin
        if (sqrt_done) d_r <= sqrt_root;
      end
      ST_HIT: begin
        ex_r  <= ex_full[32:0];
        cnt_r <= '0;
        if (d_r == '0) begin
          f_r <= '0;
        end else if (ex_full > {7'd0, d_r}) begin
          f_r <= PLPD_ONE_Q30[30:0];
        end
      end
      ST_F_W: begin
        if (div_done) begin
          f_r <= (div_quo > PLPD_ONE_Q30) ? PLPD_ONE_Q30[30:0] : div_quo[30:0];
        end
      end
      ST_POS: begin
        if (cnt_r != 3'd0) begin
          pos_r[pidx] <= seg_r[pidx][32] ? cur_r[pidx] + dm[31:0]
                                         : cur_r[pidx] - dm[31:0];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd3) begin
          nv_r[0] <= {{31{seg_r[1][32]}}, seg_r[1]};
          nv_r[1] <= 64'd0 - {{31{seg_r[0][32]}}, seg_r[0]};
          nv_r[2] <= '0;
          phase_r <= PH_SIDE;
        end
      end
      ST_N_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          na_r[i] <= mag64(nv_r[i]);
        end
        nm_r <= nmax;
      end
      ST_N_SHIFT: begin
        cnt_r <= '0;
        ns_r  <= '0;
        if (nm_r == '0) begin
          nq_r <= '0;
        end else if (nm_r >= 64'h8000_0000) begin
          nm_r <= nm_r >> 1;
          for (int i = 0; i < 3; i++) na_r[i] <= na_r[i] >> 1;
        end else if (nm_r < 64'h4000_0000) begin
          nm_r <= nm_r << 1;
          for (int i = 0; i < 3; i++) na_r[i] <= na_r[i] << 1;
        end
      end
      ST_N_SQ: begin
        if (cnt_r != 3'd0) ns_r <= ns_r + prod_r[63:0];
        cnt_r <= cnt_r + 1'b1;
      end
      ST_N_RT_W: begin
        if (sqrt_done) begin
          nn_r  <= sqrt_root;
          cnt_r <= '0;
        end
      end
      ST_N_DIV_W: begin
        if (div_done) begin
          nq_r[cnt_r[1:0]] <= nv_r[cnt_r[1:0]][63] ? 32'd0 - div_quo : div_quo;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_N_RET: begin
        cnt_r <= '0;
        unique case (phase_r)
          PH_SIDE: begin
            side_r  <= nq_r;
            phase_r <= PH_FWD;
            for (int i = 0; i < 3; i++) nv_r[i] <= {{31{seg_r[i][32]}}, seg_r[i]};
          end
          PH_FWD:  fwd_r <= nq_r;
          PH_NRM:  nrm_r <= nq_r;
          default: nrm_r <= nq_r;
        endcase
      end
      ST_X_MUL: begin
        unique case (cnt_r)
          3'd1:    nv_r[0] <= prod_r[63:0];
          3'd2:    nv_r[1] <= 64'd0 - prod_r[63:0];
          3'd3:    nv_r[2] <= prod_r[63:0];
          3'd4:    nv_r[2] <= nv_r[2] - prod_r[63:0];
          default: nv_r[0] <= nv_r[0];
        endcase
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd4) phase_r <= PH_NRM;
      end
      ST_FIN: begin
        // polyline ended without reaching the target: identity frame
        if (last_r && !emitted_r) begin
          side_r <= {32'd0, 32'd0, PLPD_ONE_Q30};
          nrm_r  <= {32'd0, PLPD_ONE_Q30, 32'd0};
          fwd_r  <= {PLPD_ONE_Q30, 32'd0, 32'd0};
          pos_r  <= '0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_r.side <= side_r;
          out_r.nrm  <= nrm_r;
          out_r.fwd  <= fwd_r;
          out_r.pos  <= pos_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_N_SQ && cnt_r == 3'd0) |->
      (nm_r >= 64'h4000_0000 && nm_r < 64'h8000_0000))
    else $error("normalize shift left magnitude out of range");

  a_factor_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POS) |-> ({1'b0, f_r} <= PLPD_ONE_Q30))
    else $error("interpolation factor above one");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_F_W || state_r == ST_N_DIV_W))
    else $error("divider finished outside a wait state");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == ST_SEG_RT_W || state_r == ST_N_RT_W))
    else $error("square root finished outside a wait state");

endmodule

`default_nettype wire

[hw/rtl/polyline_placement_at_distance_top.sv]
// ----------------------------------------------------------------------------
// polyline_placement_at_distance_top
// Samples position and frame at a set arc length along a polyline.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_point_x/y/z, in_last_point
//  out     | out_valid / out_ready  | out_side_*, out_normal_*, out_forward_*, out_pos_*
//  cfg     | cfg_wr_en              | cfg_wr_data (target_length)
//
//  a vertex with no open segment just passes the back (emitting the identity
//  result if it closes an unplaced polyline), a missed segment runs a 33-step
//  root, and the hitting vertex adds the divider and three normalizations, each
//  with a shift search, a 33-step root and three 32-step divisions. the front
//  takes a vertex per cycle, unless the queue is full, into a short request
//  queue; the output register lets the back go on while a result waits.
//  reset is synchronous, active low, and clears the queue and arc state.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_placement_at_distance_top #(
  parameter int unsigned QUEUE_DEPTH = plpd_pkg::PLPD_QDEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic               in_last_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_side_x,
  output logic signed [31:0]      out_side_y,
  output logic signed [31:0]      out_side_z,
  output logic signed [31:0]      out_normal_x,
  output logic signed [31:0]      out_normal_y,
  output logic signed [31:0]      out_normal_z,
  output logic signed [31:0]      out_forward_x,
  output logic signed [31:0]      out_forward_y,
  output logic signed [31:0]      out_forward_z,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z
);
  import plpd_pkg::*;

  plpd_entry_t  push_entry;
  plpd_q_t      head;
  plpd_result_t result;
  logic         push, q_full, pop;

  plpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_last_point (in_last_point),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_entry)
  );

  plpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  plpd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  assign out_side_x    = result.side[0];
  assign out_side_y    = result.side[1];
  assign out_side_z    = result.side[2];
  assign out_normal_x  = result.nrm[0];
  assign out_normal_y  = result.nrm[1];
  assign out_normal_z  = result.nrm[2];
  assign out_forward_x = result.fwd[0];
  assign out_forward_y = result.fwd[1];
  assign out_forward_z = result.fwd[2];
  assign out_pos_x     = result.pos[0];
  assign out_pos_y     = result.pos[1];
  assign out_pos_z     = result.pos[2];

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds polylines to the placement block under several target lengths and
// idle patterns, predicts each sampled position and frame in fixed point and
// checks every result field in order of arrival.
// ----------------------------------------------------------------------------

module testbench;
  import plpd_pkg::*;

  localparam longint unsigned RUN_MAX = (64'd1 << 40) - 1;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam int SETTLE_CYCLES = 1000;

  typedef longint vec_t [3];
  typedef struct {
    logic [31:0] side [3];
    logic [31:0] nrm [3];
    logic [31:0] fwd [3];
    logic [31:0] pos [3];
  } frame_t;

  // how a directed row states its result
  typedef enum int {EXP_PREDICT, EXP_IDENTITY, EXP_FLAT} exp_kind_t;

  typedef struct {
    bit          set_target;
    logic [31:0] target;
    logic [31:0] x, y, z;
    bit          lastv;
    exp_kind_t   kind;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic        in_last_point;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_side_x, out_side_y, out_side_z;
  logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;
  logic signed [31:0] out_forward_x, out_forward_y, out_forward_z;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;

  polyline_placement_at_distance_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_side_x(out_side_x), .out_side_y(out_side_y), .out_side_z(out_side_z),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_forward_x(out_forward_x), .out_forward_y(out_forward_y),
    .out_forward_z(out_forward_z),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

  // arc state of the predictor
  longint unsigned target_len;
  longint          prev_pt [3];
  longint unsigned arc_len;
  bit              have_prev;
  bit              placed;

  frame_t placements [$];
  int     fails;
  int     snd_idle_pct;
  int     rcv_stall_pct;
  int     hold_cycles;
  int     sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned umag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root128(logic [127:0] v);
    logic [127:0] rem;
    logic [127:0] trial;
    longint unsigned r;
    r = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (128'(r) << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic vec_t unit3(vec_t v);
    longint unsigned a [3];
    longint unsigned m, s, n, q;
    vec_t o;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = umag(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < ONE_Q30) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
    n = root128(128'(s));
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + n / 2) / n;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic frame_t identity_frame();
    frame_t r;
    for (int i = 0; i < 3; i++) begin
      r.side[i] = 0;
      r.nrm[i] = 0;
      r.fwd[i] = 0;
      r.pos[i] = 0;
    end
    r.side[0] = PLPD_ONE_Q30;
    r.nrm[1] = PLPD_ONE_Q30;
    r.fwd[2] = PLPD_ONE_Q30;
    return r;
  endfunction

  // advances the arc state by one vertex, returns 1 when a placement results
  function automatic bit place_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                      bit lastv, output frame_t r);
    longint cur [3];
    vec_t t, sraw, side, fwd, nraw, nrm;
    logic [127:0] sq;
    longint unsigned d, f, ex, dm;
    longint delta;
    bit hit;
    hit = 0;
    r = identity_frame();
    cur[0] = longint'($signed(px));
    cur[1] = longint'($signed(py));
    cur[2] = longint'($signed(pz));
    if (have_prev && !placed) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        t[i] = cur[i] - prev_pt[i];
        sq = sq + 128'(umag(t[i])) * 128'(umag(t[i]));
      end
      d = root128(sq);
      arc_len = arc_len + d;
      if (arc_len > RUN_MAX) arc_len = RUN_MAX;
      if (arc_len >= target_len) begin
        f = 0;
        if (d != 0) begin
          ex = arc_len - target_len;
          f = (ex > d) ? ONE_Q30 : (ex << 30) / d;
          if (f > ONE_Q30) f = ONE_Q30;
        end
        sraw = '{t[1], -t[0], 0};
        side = unit3(sraw);
        fwd = unit3(t);
        nraw = '{side[1] * fwd[2], -side[0] * fwd[2], side[0] * fwd[1] - side[1] * fwd[0]};
        nrm = unit3(nraw);
        for (int i = 0; i < 3; i++) begin
          dm = (umag(t[i]) * f + (64'd1 << 29)) >> 30;
          delta = t[i] < 0 ? -longint'(dm) : longint'(dm);
          r.side[i] = 32'(side[i]);
          r.nrm[i] = 32'(nrm[i]);
          r.fwd[i] = 32'(fwd[i]);
          r.pos[i] = 32'(cur[i] - delta);
        end
        placed = 1;
        hit = 1;
      end
    end
    if (lastv) begin
      if (!placed) begin
        r = identity_frame();
        hit = 1;
      end
      prev_pt = '{0, 0, 0};
      arc_len = 0;
      have_prev = 0;
      placed = 0;
    end else begin
      prev_pt = cur;
      have_prev = 1;
    end
    return hit;
  endfunction

  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit lastv,
                             exp_kind_t kind);
    int gap;
    frame_t r;
    bit hit;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_last_point <= lastv;
    do @(posedge clk); while (!in_ready);
    sent++;
    hit = place_vertex(px, py, pz, lastv, r);
    if (kind == EXP_IDENTITY) begin
      r = identity_frame();
    end else if (kind == EXP_FLAT) begin
      for (int i = 0; i < 3; i++) begin
        r.side[i] = 0;
        r.nrm[i] = 0;
        r.fwd[i] = 0;
      end
      r.pos = '{px, py, pz};
    end
    if (hit || kind != EXP_PREDICT) placements = {placements, r};
  endtask

  // sender pauses until every placement is back and the back end is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    target_len = v;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    frame_t e;
    if (rst_n && out_valid && out_ready) begin
      if (placements.size() == 0) begin
        $error("placement output with none pending");
        fails++;
      end else begin
        e = placements.pop_front();
        check_field("side_x", e.side[0], out_side_x);
        check_field("side_y", e.side[1], out_side_y);
        check_field("side_z", e.side[2], out_side_z);
        check_field("normal_x", e.nrm[0], out_normal_x);
        check_field("normal_y", e.nrm[1], out_normal_y);
        check_field("normal_z", e.nrm[2], out_normal_z);
        check_field("forward_x", e.fwd[0], out_forward_x);
        check_field("forward_y", e.fwd[1], out_forward_y);
        check_field("forward_z", e.fwd[2], out_forward_z);
        check_field("pos_x", e.pos[0], out_pos_x);
        check_field("pos_y", e.pos[1], out_pos_y);
        check_field("pos_z", e.pos[2], out_pos_z);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  function automatic logic [31:0] step_coord(logic [31:0] base);
    int mode;
    mode = $urandom_range(99);
    if (mode < 4) return $urandom;
    if (mode < 10) return base;
    return base + 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
  endfunction

  task automatic send_polyline();
    int nverts;
    logic [31:0] x, y, z;
    nverts = $urandom_range(1, 8);
    if ($urandom_range(9) == 0) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else begin
      x = 32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
      y = 32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
      z = 32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
    end
    for (int v = 0; v < nverts; v++) begin
      send_vertex(x, y, z, v == nverts - 1, EXP_PREDICT);
      x = step_coord(x);
      y = step_coord(y);
      // a fixed step up in z now and then
      z = ($urandom_range(9) == 0) ? z + 32'h10000 : step_coord(z);
      if ($urandom_range(19) == 0) begin
        x = step_coord(x);
        y = x;
      end
    end
  endtask

  row_t directed [] = '{
    '{0, 0, 32'h0, 32'h0, 32'h0, 1, EXP_IDENTITY},
    '{0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, EXP_PREDICT},
    '{0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 1, EXP_PREDICT},
    '{0, 0, 32'h5, 32'h5, 32'h5, 0, EXP_PREDICT},
    '{0, 0, 32'h5, 32'h5, 32'h5, 1, EXP_FLAT},
    '{0, 0, 32'h0, 32'h0, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h0, 32'h0, 32'h10000, 1, EXP_PREDICT},
    '{0, 0, 32'h0, 32'h0, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h10000, 32'h0, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h0, 32'h10000, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h1, 32'h1, 32'h1, 1, EXP_PREDICT},
    '{1, 32'hffffffff, 0, 0, 0, 0, EXP_PREDICT},
    '{0, 0, 32'h1, 32'h2, 32'h3, 0, EXP_PREDICT},
    '{0, 0, 32'h4, 32'h5, 32'h6, 1, EXP_IDENTITY},
    '{1, 32'h100000, 0, 0, 0, 0, EXP_PREDICT},
    '{0, 0, 32'h0, 32'h0, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h10000, 32'h0, 32'h0, 0, EXP_PREDICT},
    // lower the target with the polyline still open
    '{1, 32'h8000, 0, 0, 0, 0, EXP_PREDICT},
    '{0, 0, 32'h20000, 32'h0, 32'h0, 1, EXP_PREDICT},
    '{1, 32'h18000, 0, 0, 0, 0, EXP_PREDICT},
    '{0, 0, 32'hfffe0000, 32'h30000, 32'h0, 0, EXP_PREDICT},
    '{0, 0, 32'h10000, 32'hffff0000, 32'h8000, 0, EXP_PREDICT},
    '{0, 0, 32'h10000, 32'hffff0000, 32'h8000, 1, EXP_PREDICT}
  };

  initial begin
    logic [31:0] tgt;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    in_last_point = 1'b0;
    out_ready = 1'b0;
    fails = 0;
    sent = 0;
    hold_cycles = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    target_len = 0;
    prev_pt = '{0, 0, 0};
    arc_len = 0;
    have_prev = 0;
    placed = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].set_target) begin
        drain();
        write_target(directed[i].target);
      end else begin
        send_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].lastv,
                    directed[i].kind);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
      endcase
      case (ph)
        0: tgt = 32'h0;
        3: tgt = 32'hffffffff;
        5: tgt = $urandom;
        default: tgt = $urandom_range(0, 32'h200000);
      endcase
      write_target(tgt);
      // receiver holds off while requests keep coming
      if (ph == 4) hold_cycles = 4000;
      while (sent < 23 + (ph + 1) * 166) send_polyline();
    end

    drain();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/plpd_pkg.sv
hw/rtl/plpd_front.sv
hw/rtl/plpd_queue.sv
hw/rtl/plpd_sqrt.sv
hw/rtl/plpd_div.sv
hw/rtl/plpd_back.sv
hw/rtl/polyline_placement_at_distance_top.sv
verif/testbench.sv
